/* rtl/tcw_pkg.sv */
// Shared types and constants of the text console writer
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 30;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int CELL_AW = $clog2(CELLS);

  // field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // command codes
  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_CALC   = 2'd1,
    ST_ACCESS = 2'd2,
    ST_FINISH = 2'd3
  } st_e;

  // input request
  typedef struct packed {
    logic [1:0]       command;
    logic [7:0]       char_code;
    logic [3:0]       foreground;
    logic [3:0]       background;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_column;
  } tcw_in_t;

  // result request
  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [COL_W-1:0]  cursor_column_now;
    logic [ROW_W-1:0]  cursor_row_now;
    logic              scrolled;
  } tcw_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic take_item;
    logic calc_en;
    logic access_en;
    logic load_out;
  } tcw_cmd_t;

endpackage

`default_nettype wire

/* rtl/tcw_ctrl.sv */
// Controller state machine of the text console writer
`default_nettype none

module tcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcw_pkg::tcw_cmd_t cmd_o
);
  import tcw_pkg::*;

  st_e  state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // output register can take a new result
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CALC;
      end
      ST_CALC:   state_d = ST_ACCESS;
      ST_ACCESS: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o      = 1'b1;
    cmd_o.take_item = 1'b0;
    cmd_o.calc_en   = 1'b0;
    cmd_o.access_en = 1'b0;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.take_item = in_valid_i;
      end
      ST_CALC:   cmd_o.calc_en = 1'b1;
      ST_ACCESS: cmd_o.access_en = 1'b1;
      ST_FINISH: cmd_o.load_out = out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_CALC))
    else $error("accepted request did not start address calculation");

  a_access_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACCESS) |-> ($past(state_q) == ST_CALC))
    else $error("memory access without address calculation");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.take_item, cmd_o.calc_en, cmd_o.access_en, cmd_o.load_out}))
    else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

/* rtl/tcw_dp.sv */
// Datapath of the text console writer: cursor, cell memory, row fill ranges
`default_nettype none

module tcw_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tcw_pkg::tcw_cmd_t         cmd_i,
  input  tcw_pkg::tcw_in_t          in_data_i,
  input  logic                      cfg_we_i,
  input  logic [tcw_pkg::COL_W-1:0] cfg_data_i,
  output tcw_pkg::tcw_out_t         out_data_o
);
  import tcw_pkg::*;

  tcw_in_t           item_q;
  logic [COL_W-1:0]  margin_q;
  logic [COL_W-1:0]  cur_col_q;
  logic [ROW_W-1:0]  cur_row_q;
  logic [ROW_W-1:0]  top_q;
  logic [ROW_W-1:0]  prow_q, prow_d;
  logic              in_range_q, in_range_d;
  logic              hit_q, hit_d;
  logic              scrolled_q;
  logic [ROWS-1:0]   rv_q;
  logic [COL_W-1:0]  lo_q [ROWS];
  logic [COL_W-1:0]  hi_q [ROWS];
  logic [CELL_W-1:0] mem_q [CELLS];
  logic [CELL_W-1:0] rdata_q;
  tcw_out_t          out_q, out_d;

  logic              is_put, is_clear, is_read, is_nl;
  logic [ROW_W-1:0]  row_sel;
  logic [ROW_W:0]    row_sum;
  logic [COL_W-1:0]  acc_col, col_inc, margin_eff;
  logic [CELL_AW-1:0] addr;
  logic [CELL_W-1:0] cell_wr;
  logic              do_write, wrap, last_row, scroll;

  // request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) item_q <= in_data_i;
  end

  // decode
  assign is_put   = (item_q.command == CMD_PUT);
  assign is_clear = (item_q.command == CMD_CLEAR);
  assign is_read  = (item_q.command == CMD_READ);
  assign is_nl    = (item_q.char_code == NEWLINE_CODE);

  // physical row through the ring offset
  always_comb begin
    in_range_d = (item_q.read_row < ROW_W'(ROWS)) && (item_q.read_column < COL_W'(COLUMNS));
    row_sel    = is_read ? item_q.read_row : cur_row_q;
    row_sum    = {1'b0, row_sel} + {1'b0, top_q};
    if (row_sum >= (ROW_W+1)'(ROWS)) begin
      prow_d = ROW_W'(row_sum - (ROW_W+1)'(ROWS));
    end else begin
      prow_d = ROW_W'(row_sum);
    end
    if (is_read && !in_range_d) prow_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_en) begin
      prow_q     <= prow_d;
      in_range_q <= in_range_d;
    end
  end

  // cell address and cursor advance
  always_comb begin
    acc_col    = cur_col_q;
    if (is_read) acc_col = in_range_q ? item_q.read_column : '0;
    addr       = CELL_AW'(CELL_AW'(prow_q) * CELL_AW'(COLUMNS)) + CELL_AW'(acc_col);
    cell_wr    = {item_q.foreground, item_q.background, item_q.char_code};
    col_inc    = cur_col_q + COL_W'(1);
    margin_eff = (margin_q >= COL_W'(COLUMNS)) ? COL_W'(COLUMNS - 1) : margin_q;
    do_write   = cmd_i.access_en && is_put && !is_nl;
    wrap       = is_put && (is_nl || (cur_col_q == COL_W'(COLUMNS - 1)));
    last_row   = (cur_row_q == ROW_W'(ROWS - 1));
    scroll     = wrap && last_row;
    // a cell holds data only inside its row's written column range
    hit_d      = in_range_q && rv_q[prow_q] && (acc_col >= lo_q[prow_q])
                 && (acc_col < hi_q[prow_q]);
  end

  // cursor, scroll offset, margin and row valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q   <= '0;
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      top_q      <= '0;
      rv_q       <= '0;
      scrolled_q <= 1'b0;
    end else begin
      if (cfg_we_i) margin_q <= cfg_data_i;
      if (cmd_i.access_en) begin
        scrolled_q <= scroll;
        if (is_clear) begin
          cur_col_q <= '0;
          cur_row_q <= '0;
          top_q     <= '0;
          rv_q      <= '0;
        end else if (is_put) begin
          if (!is_nl) rv_q[prow_q] <= 1'b1;
          if (wrap) begin
            cur_col_q <= margin_eff;
            if (last_row) begin
              // old top row becomes the blank bottom row
              rv_q[top_q] <= 1'b0;
              top_q       <= (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + ROW_W'(1);
            end else begin
              cur_row_q <= cur_row_q + ROW_W'(1);
            end
          end else begin
            cur_col_q <= col_inc;
          end
        end
      end
    end
  end

  // written column range per physical row
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      if (!rv_q[prow_q]) lo_q[prow_q] <= cur_col_q;
      hi_q[prow_q] <= col_inc;
    end
  end

  // cell memory
  always_ff @(posedge clk_i) begin
    if (do_write) mem_q[addr] <= cell_wr;
    if (cmd_i.access_en) begin
      rdata_q <= mem_q[addr];
      hit_q   <= hit_d;
    end
  end

  // result register
  always_comb begin
    out_d.cell_value        = (is_read && hit_q) ? rdata_q : '0;
    out_d.cursor_column_now = cur_col_q;
    out_d.cursor_row_now    = cur_row_q;
    out_d.scrolled          = scrolled_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_q <= out_d;
  end

  assign out_data_o = out_q;

`ifndef ASSERT_OFF
  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_col_q < COL_W'(COLUMNS)) && (cur_row_q < ROW_W'(ROWS)))
    else $error("cursor left the screen");

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q < ROW_W'(ROWS))
    else $error("scroll offset out of range");

  a_scroll_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scrolled_q |-> (cur_row_q == ROW_W'(ROWS - 1)))
    else $error("scroll without cursor on the bottom row");
`endif

endmodule

`default_nettype wire

/* rtl/text_console_writer_top.sv */
// Top level of the text console writer
//
//  channel   direction  handshake              payload
//  in        input      in_valid_i/in_stall_o    in_data_i (tcw_in_t)
//  out       output     out_valid_o/out_stall_i  out_data_o (tcw_out_t)
//  cfg       input      cfg_valid_i/cfg_ready_o  cfg_data_i (left margin)
//
// Each request passes through accept, physical row calculation, memory access
// and result load in turn; a new request is taken only once the last is loaded.
// A result waiting on out_stall_i holds the controller before its load step.
// Reset clears cursor, scroll offset, margin and the per-row valid flags;
// the cell memory itself is never swept, rows not valid read as zero.
`default_nettype none

module text_console_writer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  tcw_pkg::tcw_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output tcw_pkg::tcw_out_t         out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tcw_pkg::COL_W-1:0] cfg_data_i
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;

  // margin register always takes a write
  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tcw_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

/* verif/text_console_writer_top_test.sv */
// Self-checking testbench for the text console writer top level
`timescale 1ns / 1ps

module text_console_writer_top_test;
  import tcw_pkg::*;

  localparam int          CLK_PERIOD     = 10;
  localparam int          RESET_CYCLES   = 5;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          END_WAIT       = 12;
  localparam int          RANDOM_PHASES  = 6;
  localparam int          PHASE_ITEMS    = 100;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;

  // block ports
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  tcw_in_t           in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  tcw_out_t          out_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [COL_W-1:0]  cfg_data_i  = '0;

  // shadow copy of the console state
  logic [CELL_W-1:0] shadow_cells [CELLS];
  int unsigned       shadow_col    = 0;
  int unsigned       shadow_row    = 0;
  int unsigned       shadow_top    = 0;
  int unsigned       shadow_margin = 0;

  tcw_out_t          console_expect_q [$];

  // run bookkeeping
  bit                quiet_mode      = 1'b0;
  bit                stall_enable    = 1'b1;
  int unsigned       stall_left      = 0;
  int unsigned       idle_cycles     = 0;
  int unsigned       mismatch_count  = 0;
  int unsigned       request_count   = 0;
  int unsigned       result_count    = 0;
  int unsigned       read_count      = 0;
  int unsigned       clear_count     = 0;
  int unsigned       scroll_count    = 0;
  int unsigned       margin_writes   = 0;

  text_console_writer_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // advance the shadow console by one request and return its result
  function automatic tcw_out_t predict_console(tcw_in_t req);
    tcw_out_t    res;
    int unsigned prow;
    int unsigned base;
    bit          wrap;
    res = '0;
    wrap = 1'b0;
    case (req.command)
      CMD_PUT: begin
        if (req.char_code != NEWLINE_CODE) begin
          prow = (shadow_row + shadow_top) % ROWS;
          shadow_cells[prow * COLUMNS + shadow_col] =
            {req.foreground, req.background, req.char_code};
          shadow_col++;
          wrap = (shadow_col >= COLUMNS);
        end else begin
          wrap = 1'b1;
        end
        if (wrap) begin
          // an oversized margin behaves as the last column
          shadow_col = (shadow_margin < COLUMNS) ? shadow_margin : COLUMNS - 1;
          shadow_row++;
          if (shadow_row >= ROWS) begin
            // old top row is blanked and becomes the bottom row
            base = shadow_top * COLUMNS;
            for (int i = 0; i < COLUMNS; i++) shadow_cells[base + i] = '0;
            shadow_top   = (shadow_top + 1) % ROWS;
            shadow_row   = ROWS - 1;
            res.scrolled = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;
        shadow_col = 0;
        shadow_row = 0;
        shadow_top = 0;
      end
      CMD_READ: begin
        if (req.read_row < ROWS && req.read_column < COLUMNS) begin
          prow = (req.read_row + shadow_top) % ROWS;
          res.cell_value = shadow_cells[prow * COLUMNS + req.read_column];
        end
      end
      default: begin
        // unused command leaves everything as it is
      end
    endcase
    res.cursor_column_now = COL_W'(shadow_col);
    res.cursor_row_now    = ROW_W'(shadow_row);
    return res;
  endfunction

  function automatic tcw_in_t make_req(logic [1:0] cmd, logic [7:0] code, logic [3:0] fg,
                                       logic [3:0] bg, logic [ROW_W-1:0] row,
                                       logic [COL_W-1:0] col);
    tcw_in_t req;
    req.command     = cmd;
    req.char_code   = code;
    req.foreground  = fg;
    req.background  = bg;
    req.read_row    = row;
    req.read_column = col;
    return req;
  endfunction

  // random request, weighted toward writes and reads of live cells
  function automatic tcw_in_t random_request();
    tcw_in_t     req;
    int unsigned pick;
    req = make_req(CMD_PUT, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)), ROW_W'($urandom_range(0, 31)),
                   COL_W'($urandom_range(0, 127)));
    pick = $urandom_range(0, 99);
    if (pick < 52) begin
      req.command = CMD_PUT;
    end else if (pick < 60) begin
      req.command   = CMD_PUT;
      req.char_code = NEWLINE_CODE;
    end else if (pick < 92) begin
      req.command = CMD_READ;
      if ($urandom_range(0, 9) < 4) begin
        req.read_row    = ROW_W'(shadow_row);
        req.read_column = COL_W'($urandom_range(0, COLUMNS - 1));
      end else if ($urandom_range(0, 9) < 8) begin
        req.read_row    = ROW_W'($urandom_range(0, ROWS - 1));
        req.read_column = COL_W'($urandom_range(0, COLUMNS - 1));
      end
    end else if (pick < 94) begin
      req.command = CMD_CLEAR;
    end else begin
      req.command = CMD_UNUSED;
    end
    return req;
  endfunction

  // send one request, with a random gap ahead of it unless quiet mode is on
  task automatic send_request(tcw_in_t req);
    int unsigned gap;
    gap = quiet_mode ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // hold the sender until every pending result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    // let the monitor log the last accepted request first
    @(posedge clk_i);
    while (console_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_margin(logic [COL_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic report_field(string name, logic [CELL_W-1:0] exp_v,
                              logic [CELL_W-1:0] got_v);
    if (got_v !== exp_v) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("result %0d: %s expected %h, got %h", result_count, name, exp_v, got_v);
    end
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_enable && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: config writes, accepted requests, accepted results, watchdog
  always @(posedge clk_i) begin
    tcw_out_t exp_res;
    bit       moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        shadow_margin = 32'(cfg_data_i);
        margin_writes++;
        moved = 1'b1;
      end
      if (in_valid_i && !in_stall_o) begin
        exp_res = predict_console(in_data_i);
        console_expect_q.push_back(exp_res);
        request_count++;
        if (in_data_i.command == CMD_READ) read_count++;
        if (in_data_i.command == CMD_CLEAR) clear_count++;
        if (exp_res.scrolled) scroll_count++;
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        result_count++;
        moved = 1'b1;
        if (console_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result %0d arrived with no pending request: %p",
                     result_count, out_data_o);
        end else begin
          exp_res = console_expect_q.pop_front();
          report_field("cell_value", exp_res.cell_value, out_data_o.cell_value);
          report_field("cursor_column_now", CELL_W'(exp_res.cursor_column_now),
                       CELL_W'(out_data_o.cursor_column_now));
          report_field("cursor_row_now", CELL_W'(exp_res.cursor_row_now),
                       CELL_W'(out_data_o.cursor_row_now));
          report_field("scrolled", CELL_W'(exp_res.scrolled),
                       CELL_W'(out_data_o.scrolled));
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results pending",
               idle_cycles, console_expect_q.size());
      $display("FAIL text_console_writer_top");
      $finish;
    end
  end

  // blank screen after reset, margin at its reset value
  task automatic test_after_reset();
    write_margin(7'd0);
    send_request(make_req(CMD_READ, 8'd0, 4'd0, 4'd0, 5'd0, 7'd0));
    send_request(make_req(CMD_READ, 8'd0, 4'd0, 4'd0, ROW_W'(ROWS - 1),
                          COL_W'(COLUMNS - 1)));
    drain_results();
  endtask

  // field extremes, code zero, high codes, newline, unused command, bad reads
  task automatic test_field_extremes();
    send_request(make_req(CMD_PUT, 8'd0, 4'd0, 4'd0, 5'd0, 7'd0));
    send_request(make_req(CMD_PUT, 8'hFF, 4'hF, 4'hF, 5'h1F, 7'h7F));
    send_request(make_req(CMD_PUT, 8'h80, 4'h5, 4'hA, 5'd0, 7'd0));
    send_request(make_req(CMD_PUT, 8'h7F, 4'hA, 4'h5, 5'd0, 7'd0));
    send_request(make_req(CMD_UNUSED, 8'hFF, 4'hF, 4'hF, 5'h1F, 7'h7F));
    for (int c = 0; c < 5; c++)
      send_request(make_req(CMD_READ, 8'hFF, 4'hF, 4'hF, 5'd0, COL_W'(c)));
    send_request(make_req(CMD_PUT, NEWLINE_CODE, 4'hF, 4'hF, 5'd0, 7'd0));
    send_request(make_req(CMD_READ, 8'd0, 4'd0, 4'd0, ROW_W'(ROWS), 7'd0));
    send_request(make_req(CMD_READ, 8'd0, 4'd0, 4'd0, 5'h1F, 7'd1));
    send_request(make_req(CMD_READ, 8'd0, 4'd0, 4'd0, 5'd0, COL_W'(COLUMNS)));
    send_request(make_req(CMD_READ, 8'd0, 4'd0, 4'd0, 5'd0, 7'h7F));
    drain_results();
  endtask

  // oversized margins make every write wrap, which scrolls quickly
  task automatic test_margin_scroll();
    write_margin(7'h7F);
    send_request(make_req(CMD_PUT, NEWLINE_CODE, 4'd1, 4'd2, 5'd0, 7'd0));
    for (int i = 0; i < ROWS + 2; i++)
      send_request(make_req(CMD_PUT, 8'(8'h41 + i), 4'(i), 4'(~i), 5'd0, 7'd0));
    send_request(make_req(CMD_READ, 8'd0, 4'd0, 4'd0, ROW_W'(ROWS - 2),
                          COL_W'(COLUMNS - 1)));
    send_request(make_req(CMD_READ, 8'd0, 4'd0, 4'd0, ROW_W'(ROWS - 1),
                          COL_W'(COLUMNS - 1)));
    drain_results();
    write_margin(COL_W'(COLUMNS));
    send_request(make_req(CMD_PUT, 8'h5A, 4'd3, 4'd4, 5'd0, 7'd0));
    drain_results();
    write_margin(COL_W'(COLUMNS - 1));
    send_request(make_req(CMD_PUT, NEWLINE_CODE, 4'd0, 4'd0, 5'd0, 7'd0));
    drain_results();
  endtask

  // clear blanks everything and homes the cursor
  task automatic test_clear();
    send_request(make_req(CMD_CLEAR, 8'd0, 4'd0, 4'd0, 5'd0, 7'd0));
    send_request(make_req(CMD_READ, 8'd0, 4'd0, 4'd0, ROW_W'(ROWS - 2),
                          COL_W'(COLUMNS - 1)));
    send_request(make_req(CMD_PUT, 8'h33, 4'd7, 4'd8, 5'd0, 7'd0));
    send_request(make_req(CMD_READ, 8'd0, 4'd0, 4'd0, 5'd0, 7'd0));
    drain_results();
  endtask

  // random traffic in phases, margin changed between phases
  task automatic test_random_traffic();
    int unsigned phase_margin [RANDOM_PHASES];
    phase_margin = '{0, COLUMNS - 1, 127, COLUMNS, 0, 0};
    phase_margin[4] = $urandom_range(1, COLUMNS - 2);
    phase_margin[5] = $urandom_range(0, 127);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_margin(COL_W'(phase_margin[p]));
      // one phase runs back to back with no stalls
      quiet_mode   = (p == 1);
      stall_enable = (p != 1);
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());
      drain_results();
    end
    quiet_mode   = 1'b0;
    stall_enable = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_after_reset();
    test_field_extremes();
    test_margin_scroll();
    test_clear();
    test_random_traffic();
    drain_results();
    repeat (END_WAIT) @(posedge clk_i);
    $display("checked %0d results for %0d requests: %0d reads, %0d clears, %0d scrolls",
             result_count, request_count, read_count, clear_count, scroll_count);
    $display("%0d margin writes, %0d mismatches", margin_writes, mismatch_count);
    if (mismatch_count == 0 && console_expect_q.size() == 0) begin
      $display("PASS text_console_writer_top");
    end else begin
      $display("FAIL text_console_writer_top");
    end
    $finish;
  end

endmodule
